>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the modular exponentiation block.
// Depends on nothing; a user module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, idle while rst_n is low.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true on a rising edge of clk.
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/modexp_pkg.sv
// Package of the modular exponentiation block: widths, reset values and
// register index codes. Depends on nothing.
`default_nettype none

package modexp_pkg;

    // Width of the modulus, the exponent and all residues.
    localparam int MOD_BITS = 16;
    // Width of the input and result words.
    localparam int WORD_W = 16;
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;
    // Bit counter of the serial multiplier.
    localparam int CNT_W = $clog2(MOD_BITS);

    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(15943);
    localparam logic [MOD_BITS-1:0] EXPONENT_RESET = MOD_BITS'(2203);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

endpackage

`default_nettype wire

>>> src/modular_exponentiation.sv
// Top level of the modular exponentiation block: sequencer and bit-serial
// modular multiplier. Depends on modexp_pkg and assert_macros.svh.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  base_word
//   result    out        out_valid / out_stall power_result
//   config    in         cfg_we               cfg_index, cfg_data
//
// After the transfer of a base word the engine reduces the base, then
// performs each squaring and each multiplication by the current power of
// the base as a set-up step in S_STEP followed by a serial run of the
// multiplier, and finishes in S_DONE. in_stall stays high until the result
// has moved to the output register, so one base word is worked on at a time.
// All steps use the single shared multiplier, which consumes one
// bit of its left operand per cycle.
// Reset clears the control state and loads the reset values of the modulus
// and exponent registers. A result waits in the output register while
// out_stall is high; the next item may be taken meanwhile.
`default_nettype none
`include "assert_macros.svh"

module modular_exponentiation (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [modexp_pkg::WORD_W-1:0]        base_word,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [modexp_pkg::WORD_W-1:0]             power_result,
    input  wire logic                                 cfg_we,
    input  wire logic [modexp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [modexp_pkg::MOD_BITS-1:0]      cfg_data
);
    import modexp_pkg::*;

    // S_REDUCE, S_MUL and S_SQR all run the serial multiplier; they differ
    // in where the finished product goes and how the remaining exponent changes.
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_DONE
    } state_t;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MOD_BITS - 1);

    state_t                state_reg, state_next;
    logic [MOD_BITS-1:0]   modulus_reg, modulus_next;
    logic [MOD_BITS-1:0]   exponent_reg, exponent_next;
    logic [MOD_BITS-1:0]   e_reg, e_next;       // remaining exponent
    logic [MOD_BITS-1:0]   acc_reg, acc_next;   // running product
    logic [MOD_BITS-1:0]   sq_reg, sq_next;     // base raised to 2^k
    logic [MOD_BITS-1:0]   x_reg, x_next;       // multiplier, MSB first
    logic [MOD_BITS-1:0]   y_reg, y_next;       // multiplicand, below n
    logic [MOD_BITS-1:0]   r_reg, r_next;       // partial residue
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]     result_reg, result_next;

    // One step of interleaved multiply and reduce: r = 2r + x_bit * y,
    // then bring the sum below n. With r and y below n the sum stays
    // below 3n, so at most two subtractions of n are needed.
    logic [MOD_BITS+1:0]   sum_ext;
    logic [MOD_BITS+1:0]   n_ext;
    logic [MOD_BITS+1:0]   n2_ext;
    logic [MOD_BITS+1:0]   sub1;
    logic [MOD_BITS+1:0]   sub2;
    logic [MOD_BITS-1:0]   r_step;
    logic                  mul_busy;
    logic                  out_free;

    assign n_ext  = {2'b00, modulus_reg};
    assign n2_ext = {1'b0, modulus_reg, 1'b0};
    assign sum_ext = {1'b0, r_reg, 1'b0}
                   + (x_reg[MOD_BITS-1] ? {2'b00, y_reg} : '0);
    assign sub1 = sum_ext - n_ext;
    assign sub2 = sum_ext - n2_ext;

    always_comb
    begin
        if (sum_ext >= n2_ext)
        begin
            r_step = sub2[MOD_BITS-1:0];
        end
        else if (sum_ext >= n_ext)
        begin
            r_step = sub1[MOD_BITS-1:0];
        end
        else
        begin
            r_step = sum_ext[MOD_BITS-1:0];
        end
    end

    assign mul_busy = (state_reg == S_REDUCE) || (state_reg == S_MUL)
                   || (state_reg == S_SQR);
    // The output register can take a new result when it is empty or its
    // current result is transferred in this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        modulus_next   = modulus_reg;
        exponent_next  = exponent_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS:  modulus_next = cfg_data;
                REG_EXPONENT: exponent_next = cfg_data;
                default:      ;
            endcase
        end

        // Serial multiplier: shift one bit of x in per cycle.
        if (mul_busy)
        begin
            r_next   = r_step;
            x_next   = {x_reg[MOD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    e_next = exponent_reg;
                    if (modulus_reg < MOD_BITS'(2))
                    begin
                        // No residues to work in: the result is zero.
                        acc_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Reduce the base as base * 1 mod n.
                        acc_next   = MOD_BITS'(1);
                        x_next     = MOD_BITS'(base_word);
                        y_next     = MOD_BITS'(1);
                        r_next     = '0;
                        cnt_next   = CNT_MAX;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (cnt_reg == '0)
                begin
                    sq_next    = r_step;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (e_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (e_reg[0])
                begin
                    x_next     = acc_reg;
                    y_next     = sq_reg;
                    r_next     = '0;
                    cnt_next   = CNT_MAX;
                    state_next = S_MUL;
                end
                else
                begin
                    x_next     = sq_reg;
                    y_next     = sq_reg;
                    r_next     = '0;
                    cnt_next   = CNT_MAX;
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    acc_next   = r_step;
                    e_next     = {e_reg[MOD_BITS-1:1], 1'b0};
                    state_next = S_STEP;
                end
            end
            S_SQR:
            begin
                if (cnt_reg == '0)
                begin
                    sq_next    = r_step;
                    e_next     = {1'b0, e_reg[MOD_BITS-1:1]};
                    state_next = S_STEP;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = WORD_W'(acc_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= MODULUS_RESET;
            exponent_reg  <= EXPONENT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        r_reg      <= r_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_result = result_reg;

    // An accepted item either starts the reduction or goes straight to
    // the result for a degenerate modulus.
    `ASSERT_CLK(a_accept_starts, (in_valid && !in_stall) |=> (state_reg == S_REDUCE || state_reg == S_DONE), "accepted item did not start")
    // Every new multiplication starts with a full bit count.
    `ASSERT_CLK(a_mul_count, (state_reg == S_STEP && e_reg != '0) |=> (cnt_reg == CNT_MAX), "multiplier started with wrong count")
    // A finished squaring halves the remaining exponent.
    `ASSERT_CLK(a_sqr_halves, (state_reg == S_SQR && cnt_reg == '0) |=> (e_reg == ($past(e_reg) >> 1)), "squaring did not halve the exponent")
    // A multiplication by the current power of the base runs only for an odd remaining exponent.
    `ASSERT_NEVER(a_mul_odd, (state_reg == S_MUL && !e_reg[0]), "multiply with even exponent")

endmodule

`default_nettype wire
